// ----- src/cpup_pkg.sv -----
//------------------------------------------------------------------------------
// Color pointer update parser package
// Shared payload types, field indexes, result kinds and status codes.
//------------------------------------------------------------------------------
`default_nettype none

package cpup_pkg;

   // Message header layout.
   localparam int HEADER_BYTES = 14;
   localparam int HDR_CNT_W = 4;
   localparam int FIELD_COUNT = 7;
   localparam int FLD_CACHE = 0;
   localparam int FLD_HOT_X = 1;
   localparam int FLD_HOT_Y = 2;
   localparam int FLD_WIDTH = 3;
   localparam int FLD_HEIGHT = 4;
   localparam int FLD_ALEN = 5;
   localparam int FLD_XLEN = 6;

   // Body byte counter saturates at its full range.
   localparam int BODY_W = 17;
   localparam logic [BODY_W-1:0] BODY_MAX = '1;

   // Color depth register.
   localparam int BPP_W = 6;
   localparam logic [BPP_W-1:0] BPP_RESET = 6'd24;

   // Result kinds.
   localparam logic [1:0] KIND_XOR = 2'd0;
   localparam logic [1:0] KIND_AND = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_XOR_LEN_BAD = 3'd3;
   localparam logic [2:0] ST_XOR_SHORT = 3'd4;
   localparam logic [2:0] ST_AND_LEN_BAD = 3'd5;
   localparam logic [2:0] ST_AND_SHORT = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  mask_byte;
      logic [15:0] mask_offset;
      logic [2:0]  status;
      logic [15:0] cache_index;
      logic [15:0] hot_x;
      logic [15:0] hot_y;
      logic [15:0] pointer_width;
      logic [15:0] pointer_height;
      logic [15:0] xor_mask_length;
      logic [15:0] and_mask_length;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/cpup_ifs.sv -----
//------------------------------------------------------------------------------
// Color pointer update parser channels
// Byte input channel, result channel and color depth write channel.
//------------------------------------------------------------------------------
`default_nettype none

// Message byte channel.
interface cpup_req_if;
   logic              valid;
   logic              ready;
   cpup_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Result channel.
interface cpup_rsp_if;
   logic              valid;
   logic              ready;
   cpup_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Color depth register write channel.
interface cpup_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cpup_pkg::BPP_W-1:0] xor_bits_per_pixel;
   modport source (output valid, output xor_bits_per_pixel, input ready);
   modport sink (input valid, input xor_bits_per_pixel, output ready);
endinterface

`default_nettype wire

// ----- src/cpup_mul.sv -----
//------------------------------------------------------------------------------
// Shift-add multiplier
// Multiplies two unsigned operands, one multiplier bit per cycle, on a single
// shared adder. The product is valid in the cycle that done is high.
//------------------------------------------------------------------------------
`default_nettype none

module cpup_mul #(
   parameter int MC_W = 11,
   parameter int ML_W = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MC_W-1:0]      mcand,
   input  wire logic [ML_W-1:0]      mplier,
   output logic                      done,
   output logic [MC_W+ML_W-1:0]      product
);

   localparam int PR_W = MC_W + ML_W;
   localparam int CNT_W = $clog2(ML_W + 1);

   logic [PR_W-1:0]  acc_ff, acc_in;
   logic [PR_W-1:0]  mc_ff, mc_in;
   logic [ML_W-1:0]  ml_ff, ml_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   // One partial product is added per cycle.
   always_comb begin
      acc_in = acc_ff;
      mc_in = mc_ff;
      ml_in = ml_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mc_in = {{ML_W{1'b0}}, mcand};
         ml_in = mplier;
         cnt_in = CNT_W'(ML_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ml_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in = mc_ff << 1;
         ml_in = ml_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      ml_ff <= ml_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- src/color_pointer_update_parser.sv -----
//------------------------------------------------------------------------------
// Color pointer update parser
// Parses the 14-byte pointer header, checks the mask lengths with a shared
// shift-add multiplier, passes mask bytes through and reports a final status.
//------------------------------------------------------------------------------
// Header and mask bytes are taken one per cycle while the output is free; a
// mask beat is offered in the cycle after its byte is accepted. After a header
// within MAX_DIM, three multiplies check the mask lengths and no byte is taken.
// The end byte sets a pending flag, then the status beat is registered, later
// while a mask beat waits or the size check runs; no byte is taken meanwhile.
// Reset is synchronous: it clears the parser and sets the color depth to 24.
`default_nettype none

module color_pointer_update_parser #(
   parameter int MAX_DIM = 96
) (
   input wire logic    clock,
   input wire logic    reset,
   cpup_req_if.sink    req_ch,
   cpup_rsp_if.source  rsp_ch,
   cpup_csr_if.sink    csr_ch
);

   // Widths that follow from the dimension limit.
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int PA_W = cpup_pkg::BPP_W + DIM_W;
   localparam int SX_W = PA_W - 2;
   localparam int MC_W = SX_W;
   localparam int ML_W = (DIM_W > cpup_pkg::BPP_W) ? DIM_W : cpup_pkg::BPP_W;
   localparam int PR_W = MC_W + ML_W;
   localparam int CMP_W = (PR_W > 16) ? PR_W : 16;
   localparam logic [15:0] DIM_LIMIT = 16'(MAX_DIM);

   // Parser phases.
   localparam logic [2:0] PH_HEAD = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_MUL_XBITS = 3'd2;
   localparam logic [2:0] PH_MUL_XLEN = 3'd3;
   localparam logic [2:0] PH_MUL_ALEN = 3'd4;

   localparam logic [cpup_pkg::HDR_CNT_W-1:0] HDR_FULL =
      cpup_pkg::HDR_CNT_W'(cpup_pkg::HEADER_BYTES);
   localparam logic [cpup_pkg::HDR_CNT_W-1:0] HDR_LAST =
      cpup_pkg::HDR_CNT_W'(cpup_pkg::HEADER_BYTES - 1);

   logic [2:0]                        phase_ff, phase_in;
   logic [cpup_pkg::HDR_CNT_W-1:0]    hcnt_ff, hcnt_in;
   logic [15:0]                       fld_ff [cpup_pkg::FIELD_COUNT];
   logic [15:0]                       fld_in [cpup_pkg::FIELD_COUNT];
   logic [cpup_pkg::BODY_W-1:0]       body_ff, body_in;
   logic                              xok_ff, xok_in;
   logic                              aok_ff, aok_in;
   logic                              spend_ff, spend_in;
   logic [cpup_pkg::BPP_W-1:0]        bpp_ff, bpp_in;
   logic                              out_vld_ff, out_vld_in;
   cpup_pkg::rsp_type                 out_ff, out_in;

   logic                              req_ready;
   logic                              accept;
   logic                              slot_free;
   logic                              dims_ok;
   logic [DIM_W-1:0]                  w_dim;
   logic [DIM_W-1:0]                  h_dim;
   logic [15:0]                       xlen;
   logic [15:0]                       alen;
   logic [cpup_pkg::BODY_W-1:0]       xlen_ext;
   logic [cpup_pkg::BODY_W-1:0]       and_pos;
   logic                              in_xor;
   logic                              in_and;
   logic                              xor_pass;
   logic [2:0]                        status_code;
   logic [2:0]                        hidx;

   logic                              mul_start;
   logic [MC_W-1:0]                   mul_mcand;
   logic [ML_W-1:0]                   mul_mplier;
   logic                              mul_done;
   logic [PR_W-1:0]                   mul_product;

   // Scanline bytes from a bit count, rounded up to an even byte count.
   function automatic logic [SX_W-1:0] padded_bytes(input logic [PA_W-1:0] bits);
      logic [PA_W:0]   sum;
      logic [SX_W-1:0] sx;
      sum = {1'b0, bits} + (PA_W + 1)'(7);
      sx = sum[PA_W:3];
      return sx + SX_W'(sx[0]);
   endfunction

   // Shared multiplier for the mask size check.
   cpup_mul #(
      .MC_W (MC_W),
      .ML_W (ML_W)
   ) u_cpup_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   // Handshake and header-derived values.
   assign slot_free = !out_vld_ff || rsp_ch.ready;
   assign req_ready = (phase_ff == PH_HEAD || phase_ff == PH_BODY) && !spend_ff && slot_free;
   assign accept = req_ch.valid && req_ready;
   assign dims_ok = (fld_ff[cpup_pkg::FLD_WIDTH] <= DIM_LIMIT) &&
                    (fld_ff[cpup_pkg::FLD_HEIGHT] <= DIM_LIMIT);
   assign w_dim = fld_ff[cpup_pkg::FLD_WIDTH][DIM_W-1:0];
   assign h_dim = fld_ff[cpup_pkg::FLD_HEIGHT][DIM_W-1:0];
   assign xlen = fld_ff[cpup_pkg::FLD_XLEN];
   assign alen = fld_ff[cpup_pkg::FLD_ALEN];
   assign xlen_ext = {1'b0, xlen};
   assign and_pos = body_ff - xlen_ext;
   assign in_xor = body_ff < xlen_ext;
   assign in_and = !in_xor && (and_pos < {1'b0, alen});
   assign xor_pass = dims_ok && (xlen == 16'd0 || xok_ff);
   assign hidx = hcnt_ff[3:1];

   // Final status in order of precedence.
   always_comb begin
      if (hcnt_ff != HDR_FULL) begin
         status_code = cpup_pkg::ST_SHORT_HEADER;
      end else if (!dims_ok) begin
         status_code = cpup_pkg::ST_TOO_LARGE;
      end else if (xlen != 16'd0 && in_xor) begin
         status_code = cpup_pkg::ST_XOR_SHORT;
      end else if (xlen != 16'd0 && !xok_ff) begin
         status_code = cpup_pkg::ST_XOR_LEN_BAD;
      end else if (alen != 16'd0 && (and_pos < {1'b0, alen})) begin
         status_code = cpup_pkg::ST_AND_SHORT;
      end else if (alen != 16'd0 && !aok_ff) begin
         status_code = cpup_pkg::ST_AND_LEN_BAD;
      end else begin
         status_code = cpup_pkg::ST_OK;
      end
   end

   // Parser sequencer.
   always_comb begin
      phase_in = phase_ff;
      hcnt_in = hcnt_ff;
      fld_in = fld_ff;
      body_in = body_ff;
      xok_in = xok_ff;
      aok_in = aok_ff;
      spend_in = spend_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff;
      mul_start = 1'b0;
      mul_mcand = '0;
      mul_mplier = '0;

      // A taken beat frees the output register.
      if (out_vld_ff && rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      case (phase_ff)
         PH_HEAD: begin
            if (accept) begin
               for (int i = 0; i < cpup_pkg::FIELD_COUNT; i++) begin
                  if (hidx == 3'(i)) begin
                     if (hcnt_ff[0]) begin
                        fld_in[i] = {req_ch.payload.data_byte, fld_ff[i][7:0]};
                     end else begin
                        fld_in[i] = {fld_ff[i][15:8], req_ch.payload.data_byte};
                     end
                  end
               end
               hcnt_in = hcnt_ff + cpup_pkg::HDR_CNT_W'(1);
               if (hcnt_ff == HDR_LAST) begin
                  // Header complete: clamp the hotspot and, if the sizes fit, start the size check.
                  if (fld_ff[cpup_pkg::FLD_HOT_X] >= fld_ff[cpup_pkg::FLD_WIDTH]) begin
                     fld_in[cpup_pkg::FLD_HOT_X] = 16'd0;
                  end
                  if (fld_ff[cpup_pkg::FLD_HOT_Y] >= fld_ff[cpup_pkg::FLD_HEIGHT]) begin
                     fld_in[cpup_pkg::FLD_HOT_Y] = 16'd0;
                  end
                  if (dims_ok) begin
                     mul_start = 1'b1;
                     mul_mcand = MC_W'(w_dim);
                     mul_mplier = ML_W'(bpp_ff);
                     phase_in = PH_MUL_XBITS;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            if (accept) begin
               if (in_xor && xor_pass) begin
                  out_in.result_kind = cpup_pkg::KIND_XOR;
                  out_in.mask_offset = body_ff[15:0];
                  out_vld_in = 1'b1;
               end else if (in_and && xor_pass && aok_ff) begin
                  out_in.result_kind = cpup_pkg::KIND_AND;
                  out_in.mask_offset = and_pos[15:0];
                  out_vld_in = 1'b1;
               end
               out_in.mask_byte = req_ch.payload.data_byte;
               out_in.status = cpup_pkg::ST_OK;
               out_in.cache_index = fld_ff[cpup_pkg::FLD_CACHE];
               out_in.hot_x = fld_ff[cpup_pkg::FLD_HOT_X];
               out_in.hot_y = fld_ff[cpup_pkg::FLD_HOT_Y];
               out_in.pointer_width = fld_ff[cpup_pkg::FLD_WIDTH];
               out_in.pointer_height = fld_ff[cpup_pkg::FLD_HEIGHT];
               out_in.xor_mask_length = xlen;
               out_in.and_mask_length = alen;
               if (body_ff != cpup_pkg::BODY_MAX) begin
                  body_in = body_ff + cpup_pkg::BODY_W'(1);
               end
            end
         end
         PH_MUL_XBITS: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_mcand = padded_bytes(mul_product[PA_W-1:0]);
               mul_mplier = ML_W'(h_dim);
               phase_in = PH_MUL_XLEN;
            end
         end
         PH_MUL_XLEN: begin
            if (mul_done) begin
               xok_in = CMP_W'(mul_product) == CMP_W'(xlen);
               mul_start = 1'b1;
               mul_mcand = padded_bytes(PA_W'(w_dim));
               mul_mplier = ML_W'(h_dim);
               phase_in = PH_MUL_ALEN;
            end
         end
         PH_MUL_ALEN: begin
            if (mul_done) begin
               aok_in = CMP_W'(mul_product) == CMP_W'(alen);
               phase_in = PH_BODY;
            end
         end
         default: begin
            phase_in = PH_HEAD;
         end
      endcase

      // The end byte leaves a status beat pending.
      if (accept && req_ch.payload.end_of_message) begin
         spend_in = 1'b1;
      end

      // Send the status beat and start over with a fresh message.
      if (spend_ff && (phase_ff == PH_HEAD || phase_ff == PH_BODY) && slot_free) begin
         out_in = '0;
         out_in.result_kind = cpup_pkg::KIND_STATUS;
         out_in.status = status_code;
         if (hcnt_ff == HDR_FULL) begin
            out_in.cache_index = fld_ff[cpup_pkg::FLD_CACHE];
            out_in.hot_x = fld_ff[cpup_pkg::FLD_HOT_X];
            out_in.hot_y = fld_ff[cpup_pkg::FLD_HOT_Y];
            out_in.pointer_width = fld_ff[cpup_pkg::FLD_WIDTH];
            out_in.pointer_height = fld_ff[cpup_pkg::FLD_HEIGHT];
            out_in.xor_mask_length = xlen;
            out_in.and_mask_length = alen;
         end
         out_vld_in = 1'b1;
         spend_in = 1'b0;
         phase_in = PH_HEAD;
         hcnt_in = '0;
         body_in = '0;
         xok_in = 1'b0;
         aok_in = 1'b0;
      end
   end

   // Color depth register write.
   always_comb begin
      bpp_in = bpp_ff;
      if (csr_ch.valid) begin
         bpp_in = csr_ch.xor_bits_per_pixel;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         hcnt_ff <= '0;
         body_ff <= '0;
         xok_ff <= 1'b0;
         aok_ff <= 1'b0;
         spend_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         bpp_ff <= cpup_pkg::BPP_RESET;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff <= hcnt_in;
         body_ff <= body_in;
         xok_ff <= xok_in;
         aok_ff <= aok_in;
         spend_ff <= spend_in;
         out_vld_ff <= out_vld_in;
         bpp_ff <= bpp_in;
      end
   end

   // Header fields and output payload.
   always_ff @(posedge clock) begin
      fld_ff <= fld_in;
      out_ff <= out_in;
   end

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.payload = out_ff;
   assign csr_ch.ready = 1'b1;

endmodule

`default_nettype wire

// ----- src/cpup_checker.sv -----
//------------------------------------------------------------------------------
// Color pointer update parser checker
// Port-level assertions on result sequencing and flow control, bound to the
// top level.
//------------------------------------------------------------------------------
`default_nettype none

module cpup_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_eom,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire cpup_pkg::rsp_type rsp_payload
);

   // No result beat is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   // No byte is taken while a result beat is stalled.
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while the result beat is stalled");

   // The end byte blocks input until its status beat is sent.
   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_eom |=> !req_ready)
      else $error("byte taken before the status beat of the previous message");

   // Mask beats carry an ok status field.
   a_mask_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind != cpup_pkg::KIND_STATUS
      |-> rsp_payload.status == cpup_pkg::ST_OK)
      else $error("mask beat with a nonzero status field");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

endmodule

bind color_pointer_update_parser cpup_checker u_cpup_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_eom     (req_ch.payload.end_of_message),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire
